>>> hdl/cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame transmitter package
// Shared types, register indexes, reset values and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package cft_pkg;

    localparam logic [7:0]  CFG_IDX_PAYLOAD_LENGTH = 8'd0;
    localparam logic [7:0]  CFG_IDX_START_BYTE     = 8'd1;
    localparam logic [7:0]  CFG_IDX_MESSAGE_ID     = 8'd2;
    localparam logic [7:0]  CFG_IDX_END_BYTE       = 8'd3;

    localparam logic [7:0]  RST_PAYLOAD_LENGTH = 8'd32;
    localparam logic [7:0]  RST_START_BYTE     = 8'h55;
    localparam logic [15:0] RST_MESSAGE_ID     = 16'h0001;
    localparam logic [7:0]  RST_END_BYTE       = 8'h0D;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  LEN_HI_BYTE = 8'h00;

    typedef enum logic [3:0] {
        STEP_START,
        STEP_ID_HI,
        STEP_ID_LO,
        STEP_LEN_HI,
        STEP_LEN_LO,
        STEP_PAYLOAD,
        STEP_CRC_HI,
        STEP_CRC_LO,
        STEP_END
    } step_t;

    typedef struct packed {
        logic [7:0]  payload_length;
        logic [7:0]  start_byte;
        logic [15:0] message_id;
        logic [7:0]  end_byte;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        step_t      step;
        logic       last;
    } seq_t;

    function automatic step_t next_step(input step_t s);
        step_t n;
        case (s)
            STEP_START:   n = STEP_ID_HI;
            STEP_ID_HI:   n = STEP_ID_LO;
            STEP_ID_LO:   n = STEP_LEN_HI;
            STEP_LEN_HI:  n = STEP_LEN_LO;
            STEP_LEN_LO:  n = STEP_PAYLOAD;
            STEP_PAYLOAD: n = STEP_CRC_HI;
            STEP_CRC_HI:  n = STEP_CRC_LO;
            STEP_CRC_LO:  n = STEP_END;
            default:      n = STEP_END;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/cft_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds payload length, start byte, message id and end byte.
// ----------------------------------------------------------------------------
module cft_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output cft_pkg::cfg_t cfg
);

    cft_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_length <= cft_pkg::RST_PAYLOAD_LENGTH;
            cfg_reg.start_byte     <= cft_pkg::RST_START_BYTE;
            cfg_reg.message_id     <= cft_pkg::RST_MESSAGE_ID;
            cfg_reg.end_byte       <= cft_pkg::RST_END_BYTE;
        end else if (cfg_valid) begin
            case (cfg_index)
                cft_pkg::CFG_IDX_PAYLOAD_LENGTH: cfg_reg.payload_length <= cfg_data[7:0];
                cft_pkg::CFG_IDX_START_BYTE:     cfg_reg.start_byte     <= cfg_data[7:0];
                cft_pkg::CFG_IDX_MESSAGE_ID:     cfg_reg.message_id     <= cfg_data;
                cft_pkg::CFG_IDX_END_BYTE:       cfg_reg.end_byte       <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/cft_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame sequencer
// Accepts payload words, decides header and trailer, and steps through the
// frame positions that each accepted word produces.
// ----------------------------------------------------------------------------
module cft_sequencer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_payload_byte,
    input  cft_pkg::cfg_t cfg,
    input  logic          advance,
    output cft_pkg::seq_t seq
);

    logic               item_valid_reg;
    logic [7:0]         item_byte_reg;
    logic               item_close_reg;
    cft_pkg::step_t     step_reg;
    logic [7:0]         count_reg;
    logic [7:0]         count_next;

    cft_pkg::step_t     last_step;
    logic               take;
    logic               done;
    logic               accept;
    logic               open_frame;
    logic [8:0]         sent;
    logic               close_frame;

    assign last_step = item_close_reg ? cft_pkg::STEP_END : cft_pkg::STEP_PAYLOAD;
    assign take      = item_valid_reg && advance;
    assign done      = take && (step_reg == last_step);
    assign s_ready   = !item_valid_reg || done;
    assign accept    = s_valid && s_ready;

    assign open_frame  = (count_reg == 8'd0);
    assign sent        = {1'b0, count_reg} + 9'd1;
    assign close_frame = (sent >= {1'b0, cfg.payload_length});
    assign count_next  = close_frame ? 8'd0 : sent[7:0];

    assign seq.valid = item_valid_reg;
    assign seq.data  = item_byte_reg;
    assign seq.step  = step_reg;
    assign seq.last  = (step_reg == last_step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            count_reg      <= 8'd0;
            step_reg       <= cft_pkg::STEP_PAYLOAD;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
            count_reg      <= count_next;
            step_reg       <= open_frame ? cft_pkg::STEP_START : cft_pkg::STEP_PAYLOAD;
        end else if (done) begin
            item_valid_reg <= 1'b0;
        end else if (take) begin
            step_reg <= cft_pkg::next_step(step_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_byte_reg  <= s_payload_byte;
            item_close_reg <= close_frame;
        end
    end

endmodule

>>> hdl/cft_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte emitter
// Selects the byte for each frame position, keeps the running CRC and holds
// the output register.
// ----------------------------------------------------------------------------
module cft_emitter (
    input  logic          aclk,
    input  logic          aresetn,
    input  cft_pkg::cfg_t cfg,
    input  cft_pkg::seq_t seq,
    output logic          advance,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_byte,
    output logic          m_run_last,
    output logic          m_frame_end
);

    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        frame_end_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  byte_next;

    assign advance      = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_run_last   = run_last_reg;
    assign m_frame_end  = frame_end_reg;

    always_comb begin
        byte_next = seq.data;
        crc_next  = crc_reg;
        case (seq.step)
            cft_pkg::STEP_START:   byte_next = cfg.start_byte;
            cft_pkg::STEP_ID_HI:   byte_next = cfg.message_id[15:8];
            cft_pkg::STEP_ID_LO:   byte_next = cfg.message_id[7:0];
            cft_pkg::STEP_LEN_HI:  byte_next = cft_pkg::LEN_HI_BYTE;
            cft_pkg::STEP_LEN_LO:  byte_next = cfg.payload_length;
            cft_pkg::STEP_PAYLOAD: byte_next = seq.data;
            cft_pkg::STEP_CRC_HI:  byte_next = crc_reg[15:8];
            cft_pkg::STEP_CRC_LO:  byte_next = crc_reg[7:0];
            cft_pkg::STEP_END:     byte_next = cfg.end_byte;
            default:               byte_next = seq.data;
        endcase
        case (seq.step)
            cft_pkg::STEP_CRC_HI,
            cft_pkg::STEP_CRC_LO: crc_next = crc_reg;
            cft_pkg::STEP_END:    crc_next = cft_pkg::CRC_INIT;
            default:              crc_next = cft_pkg::crc_byte(crc_reg, byte_next);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            crc_reg     <= cft_pkg::CRC_INIT;
        end else if (advance) begin
            m_valid_reg <= seq.valid;
            if (seq.valid) begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && seq.valid) begin
            byte_reg      <= byte_next;
            run_last_reg  <= seq.last;
            frame_end_reg <= (seq.step == cft_pkg::STEP_END);
        end
    end

endmodule

>>> hdl/crc16_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame transmitter
// Wraps payload words into frames with header, CRC-16/ARC and end byte.
// ----------------------------------------------------------------------------
// The first word of an item passes the sequencer item register, then the output register.
// Throughput: one output word per cycle while m_ready is high; an item yields 1, 4, 6
// or 9 words (payload only, with trailer, with header, with both), serialized by the
// single output register.
// Reset clears the frame count, the CRC and both valid flags, and loads the
// configuration registers with their reset values.
module crc16_frame_transmitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_run_last,
    output logic        m_frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cft_pkg::cfg_t cfg;
    cft_pkg::seq_t seq;
    logic          advance;

    cft_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cft_sequencer u_sequencer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .cfg            (cfg),
        .advance        (advance),
        .seq            (seq)
    );

    cft_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .seq          (seq),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_run_last   (m_run_last),
        .m_frame_end  (m_frame_end)
    );

endmodule

>>> hdl/cft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame transmitter checker
// Port-level properties of the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module cft_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte,
    input logic       m_run_last,
    input logic       m_frame_end
);

    // A stalled output word keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_byte)
            && $stable(m_run_last) && $stable(m_frame_end)))
        else $error("output word changed while stalled");

    // The end byte is always the last word of its item.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_run_last)
        else $error("end byte not marked as last word");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind crc16_frame_transmitter cft_checker u_cft_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_run_last   (m_run_last),
    .m_frame_end  (m_frame_end)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame transmitter testbench
// Sends payload bytes and register writes to the framer, predicts every framed
// word (header, payload, CRC-16/ARC trailer and end byte) and checks each
// word that leaves the block, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TOTAL_ITEMS   = 270;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
    } frame_word_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_run_last;
    logic        m_frame_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [15:0] cfg_data = 16'h0000;

    // Predicted framer state and register copies.
    logic [7:0]  reg_length = cft_pkg::RST_PAYLOAD_LENGTH;
    logic [7:0]  reg_start  = cft_pkg::RST_START_BYTE;
    logic [15:0] reg_id     = cft_pkg::RST_MESSAGE_ID;
    logic [7:0]  reg_end    = cft_pkg::RST_END_BYTE;
    logic [15:0] frame_crc  = 16'h0000;
    logic [7:0]  frame_count = 8'd0;

    frame_word_t expected_bytes[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          src_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    int          hold_req_cnt = 0;
    int          hold_ack_cnt = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    crc16_frame_transmitter u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_run_last     (m_run_last),
        .m_frame_end    (m_frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Bit-serial form of the reflected CRC-16 update, LSB of the data first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ cft_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void emit(input logic [7:0] v, input logic add_crc, input logic last,
                                 input logic fend);
        frame_word_t w;
        if (add_crc) begin
            frame_crc = crc16_update(frame_crc, v);
        end
        w.frame_byte = v;
        w.run_last   = last;
        w.frame_end  = fend;
        expected_bytes.push_back(w);
    endfunction

    function automatic void predict_frame_bytes(input logic [7:0] b);
        logic [8:0]  sent;
        logic        closing;
        logic [15:0] crc_out;
        sent    = {1'b0, frame_count} + 9'd1;
        closing = (sent >= {1'b0, reg_length});
        if (frame_count == 8'd0) begin
            emit(reg_start, 1'b1, 1'b0, 1'b0);
            emit(reg_id[15:8], 1'b1, 1'b0, 1'b0);
            emit(reg_id[7:0], 1'b1, 1'b0, 1'b0);
            emit(8'h00, 1'b1, 1'b0, 1'b0);
            emit(reg_length, 1'b1, 1'b0, 1'b0);
        end
        emit(b, 1'b1, !closing, 1'b0);
        if (closing) begin
            crc_out = frame_crc;
            emit(crc_out[15:8], 1'b0, 1'b0, 1'b0);
            emit(crc_out[7:0], 1'b0, 1'b0, 1'b0);
            emit(reg_end, 1'b0, 1'b1, 1'b1);
            frame_crc   = 16'h0000;
            frame_count = 8'd0;
        end else begin
            frame_count = sent[7:0];
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
                 want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        frame_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected word, frame_byte", m_frame_byte, 0);
            end else begin
                w = expected_bytes.pop_front();
                if (m_frame_byte !== w.frame_byte) begin
                    report_mismatch("frame_byte", m_frame_byte, w.frame_byte);
                end
                if (m_run_last !== w.run_last) begin
                    report_mismatch("run_last", m_run_last, w.run_last);
                end
                if (m_frame_end !== w.frame_end) begin
                    report_mismatch("frame_end", m_frame_end, w.frame_end);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_payload_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_frame_bytes(b);
        items_sent++;
    endtask

    task automatic drain_frames();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic write_register(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            cft_pkg::CFG_IDX_PAYLOAD_LENGTH: reg_length = data[7:0];
            cft_pkg::CFG_IDX_START_BYTE:     reg_start  = data[7:0];
            cft_pkg::CFG_IDX_MESSAGE_ID:     reg_id     = data;
            cft_pkg::CFG_IDX_END_BYTE:       reg_end    = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_values();
        send_payload_byte(8'hA5);
        drain_frames();
    endtask

    task automatic test_length_lowered();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd1);
        send_payload_byte(8'h3C);
        drain_frames();
    endtask

    task automatic test_unknown_index();
        write_register(8'd4, 16'hFFFF);
        write_register(8'hFF, 16'h1234);
        send_payload_byte(8'h81);
        drain_frames();
    endtask

    task automatic test_field_extremes();
        write_register(cft_pkg::CFG_IDX_START_BYTE, 16'h0000);
        write_register(cft_pkg::CFG_IDX_MESSAGE_ID, 16'h0000);
        write_register(cft_pkg::CFG_IDX_END_BYTE, 16'h0000);
        send_payload_byte(8'h00);
        drain_frames();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd2);
        write_register(cft_pkg::CFG_IDX_START_BYTE, 16'h00FF);
        write_register(cft_pkg::CFG_IDX_MESSAGE_ID, 16'hFFFF);
        write_register(cft_pkg::CFG_IDX_END_BYTE, 16'h00FF);
        send_payload_byte(8'hFF);
        send_payload_byte(8'h00);
        drain_frames();
    endtask

    task automatic test_zero_length();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd0);
        send_payload_byte(8'h5A);
        send_payload_byte(8'hC3);
        drain_frames();
    endtask

    task automatic test_length_above_range();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd255);
        for (int i = 0; i < 3; i++) begin
            send_payload_byte(8'($urandom_range(0, 255)));
        end
        drain_frames();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd2);
        send_payload_byte(8'h7E);
        drain_frames();
    endtask

    task automatic test_mid_frame_registers();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd3);
        send_payload_byte(8'h11);
        drain_frames();
        write_register(cft_pkg::CFG_IDX_START_BYTE, 16'h00AA);
        write_register(cft_pkg::CFG_IDX_MESSAGE_ID, 16'hBEEF);
        write_register(cft_pkg::CFG_IDX_END_BYTE, 16'h0042);
        send_payload_byte(8'h22);
        send_payload_byte(8'h33);
        send_payload_byte(8'h44);
        drain_frames();
    endtask

    task automatic test_backpressure();
        write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH, 16'd4);
        src_gaps = 1'b0;
        hold_req_cnt++;
        for (int i = 0; i < 30; i++) begin
            send_payload_byte(8'($urandom_range(0, 255)));
        end
        drain_frames();
        src_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        int          r;
        int          n;
        logic [7:0]  len;
        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = 8'($urandom_range(1, 6));
            end else if (r < 80) begin
                len = 8'($urandom_range(7, 40));
            end else if (r < 90) begin
                len = 8'd0;
            end else begin
                len = 8'($urandom_range(241, 255));
            end
            if ($urandom_range(0, 3) != 0) begin
                write_register(cft_pkg::CFG_IDX_PAYLOAD_LENGTH,
                               {8'($urandom_range(0, 255)), len});
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(cft_pkg::CFG_IDX_START_BYTE, 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(cft_pkg::CFG_IDX_MESSAGE_ID, 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_register(cft_pkg::CFG_IDX_END_BYTE, 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 9) == 0) begin
                write_register(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
            end
            r = $urandom_range(0, 3);
            src_gaps    = (r != 0);
            sink_stalls = (r != 0);
            if (reg_length >= 8'd1 && reg_length <= 8'd40) begin
                n = int'(reg_length) * int'($urandom_range(1, 2));
                if (n > 40) begin
                    n = 40;
                end
            end else begin
                n = $urandom_range(1, 12);
            end
            for (int i = 0; i < n; i++) begin
                send_payload_byte(8'($urandom_range(0, 255)));
            end
            drain_frames();
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_length_lowered();
        test_unknown_index();
        test_field_extremes();
        test_zero_length();
        test_length_above_range();
        test_mid_frame_registers();
        test_backpressure();
        test_random_frames();
        drain_frames();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
